>>> sv/drt_pkg.sv
// shared types, field widths and control bit positions for the reload timer
`timescale 1ns / 1ps
`default_nettype none

package drt_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned DATA_W = 8;

  // operation codes carried by one request
  typedef enum logic [OP_W-1:0] {
    OP_TICK         = 3'd0,
    OP_WR_CTRL      = 3'd1,
    OP_WR_RELOAD_LO = 3'd2,
    OP_WR_RELOAD_HI = 3'd3,
    OP_STAGE_CMP_LO = 3'd4,
    OP_STAGE_CMP_HI = 3'd5
  } op_e;

  // control register bit positions
  localparam int unsigned CTL_LIE  = 0;
  localparam int unsigned CTL_LOV  = 1;
  localparam int unsigned CTL_HIE  = 2;
  localparam int unsigned CTL_HOV  = 3;
  localparam int unsigned CTL_ELD  = 4;
  localparam int unsigned CTL_LONG = 5;
  localparam int unsigned CTL_LRUN = 6;
  localparam int unsigned CTL_HRUN = 7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] control_value;
    logic [DATA_W-1:0] low_count;
    logic [DATA_W-1:0] high_count;
    logic [DATA_W-1:0] compare_low;
    logic [DATA_W-1:0] compare_high;
    logic              interrupt_request;
    logic              pulse_enable;
    logic              long_mode;
    logic              half_cycle_clock;
  } result_t;

endpackage

`default_nettype wire

>>> sv/drt_if.sv
// request, result and configuration channel interfaces of the reload timer
`timescale 1ns / 1ps
`default_nettype none

interface drt_in_if;
  import drt_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output operation, output write_data, input ready);
  modport sink   (input valid, input operation, input write_data, output ready);
endinterface

interface drt_out_if;
  import drt_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] control_value;
  logic [DATA_W-1:0] low_count;
  logic [DATA_W-1:0] high_count;
  logic [DATA_W-1:0] compare_low;
  logic [DATA_W-1:0] compare_high;
  logic              interrupt_request;
  logic              pulse_enable;
  logic              long_mode;
  logic              half_cycle_clock;

  modport source (
    output valid, output control_value, output low_count, output high_count,
    output compare_low, output compare_high, output interrupt_request,
    output pulse_enable, output long_mode, output half_cycle_clock, input ready
  );
  modport sink (
    input valid, input control_value, input low_count, input high_count,
    input compare_low, input compare_high, input interrupt_request,
    input pulse_enable, input long_mode, input half_cycle_clock, output ready
  );
endinterface

interface drt_cfg_if;
  logic valid;
  logic ready;
  logic pulse_routed;

  modport source (output valid, output pulse_routed, input ready);
  modport sink   (input valid, input pulse_routed, output ready);
endinterface

`default_nettype wire

>>> sv/drt_in_reg.sv
// input register holding one request until the timer core takes it
`timescale 1ns / 1ps
`default_nettype none

module drt_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  drt_pkg::item_t in_item_i,
  output logic          in_ready_o,
  input  logic          advance_i,
  output logic          item_valid_o,
  output drt_pkg::item_t item_o
);
  import drt_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  take;

  // accept whenever empty or the held request moves on this cycle
  assign in_ready_o = ~valid_q | advance_i;
  assign take       = in_valid_i & in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  // a held request is never dropped while the core is stalled
  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !advance_i) |=> valid_q)
    else $error("held request lost while stalled");

endmodule

`default_nettype wire

>>> sv/drt_core.sv
// timer state and the single-pass step logic for one request
`timescale 1ns / 1ps
`default_nettype none

module drt_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_en_i,
  input  drt_pkg::item_t   item_i,
  input  logic             pulse_routed_i,
  output drt_pkg::result_t res_o
);
  import drt_pkg::*;

  logic [DATA_W-1:0] ctrl_q, ctrl_d;
  logic [DATA_W-1:0] reload_lo_q, reload_lo_d;
  logic [DATA_W-1:0] reload_hi_q, reload_hi_d;
  logic [DATA_W-1:0] cmp_lo_q, cmp_lo_d;
  logic [DATA_W-1:0] cmp_hi_q, cmp_hi_d;
  logic [DATA_W-1:0] stg_lo_q, stg_lo_d;
  logic [DATA_W-1:0] stg_hi_q, stg_hi_d;
  logic [DATA_W-1:0] low_q, low_d;
  logic [DATA_W-1:0] high_q, high_d;
  logic              low_run_q, low_run_d;

  logic [DATA_W:0]   lc;
  logic [DATA_W:0]   hc;
  logic [DATA_W-1:0] ctl;
  logic              lrun, hrun, lng, eld;
  logic              load_cmp;
  logic              irq;

  // next state for the request in the input register
  always_comb begin
    ctrl_d      = ctrl_q;
    reload_lo_d = reload_lo_q;
    reload_hi_d = reload_hi_q;
    cmp_lo_d    = cmp_lo_q;
    cmp_hi_d    = cmp_hi_q;
    stg_lo_d    = stg_lo_q;
    stg_hi_d    = stg_hi_q;
    low_d       = low_q;
    high_d      = high_q;
    low_run_d   = low_run_q;
    ctl         = ctrl_q;
    lrun        = ctrl_q[CTL_LRUN];
    hrun        = ctrl_q[CTL_HRUN];
    lng         = ctrl_q[CTL_LONG];
    eld         = ctrl_q[CTL_ELD];
    lc          = {1'b0, low_q};
    hc          = {1'b0, high_q};
    load_cmp    = 1'b0;
    irq         = 1'b0;

    case (item_i.op)
      OP_TICK: begin
        // low half: load on first running tick, count by two in cascade with high stopped
        if (lrun) begin
          lc = low_run_q ? {1'b0, low_q} : {1'b0, reload_lo_q};
          lc = lc + 9'd1 + {8'd0, (lng & ~hrun)};
          low_run_d = 1'b1;
        end else begin
          lc = {1'b0, reload_lo_q};
          low_run_d = 1'b0;
        end
        load_cmp = ~lrun & eld;

        // high half counts on its own only in 8-bit mode
        if (hrun) begin
          hc = lng ? {1'b0, high_q} : ({1'b0, high_q} + 9'd1);
        end else begin
          hc = {1'b0, reload_hi_q};
        end

        // low overflow reloads the low half, carry into a running high half in cascade mode
        if (lc[DATA_W]) begin
          ctl[CTL_LOV] = 1'b1;
          irq = irq | ctl[CTL_LIE];
          if (!lng) begin
            load_cmp = load_cmp | eld;
          end else if (hrun) begin
            hc = hc + 9'd1;
          end
          lc = {1'b0, reload_lo_q};
        end

        // high overflow reloads both halves in cascade mode
        if (hc[DATA_W]) begin
          ctl[CTL_HOV] = 1'b1;
          irq = irq | ctl[CTL_HIE];
          if (lng) begin
            ctl[CTL_LOV] = 1'b1;
            load_cmp = load_cmp | eld;
            lc = {1'b0, reload_lo_q};
          end
          hc = {1'b0, reload_hi_q};
        end

        if (load_cmp) begin
          cmp_lo_d = stg_lo_q;
          cmp_hi_d = stg_hi_q;
        end
        ctrl_d = ctl;
        low_d  = lc[DATA_W-1:0];
        high_d = hc[DATA_W-1:0];
      end
      OP_WR_CTRL:      ctrl_d      = item_i.data;
      OP_WR_RELOAD_LO: reload_lo_d = item_i.data;
      OP_WR_RELOAD_HI: reload_hi_d = item_i.data;
      OP_STAGE_CMP_LO: stg_lo_d    = item_i.data;
      OP_STAGE_CMP_HI: stg_hi_d    = item_i.data;
      default: begin
      end
    endcase
  end

  // timer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= '0;
      reload_lo_q <= '0;
      reload_hi_q <= '0;
      cmp_lo_q    <= '0;
      cmp_hi_q    <= '0;
      stg_lo_q    <= '0;
      stg_hi_q    <= '0;
      low_q       <= '0;
      high_q      <= '0;
      low_run_q   <= 1'b0;
    end else if (step_en_i) begin
      ctrl_q      <= ctrl_d;
      reload_lo_q <= reload_lo_d;
      reload_hi_q <= reload_hi_d;
      cmp_lo_q    <= cmp_lo_d;
      cmp_hi_q    <= cmp_hi_d;
      stg_lo_q    <= stg_lo_d;
      stg_hi_q    <= stg_hi_d;
      low_q       <= low_d;
      high_q      <= high_d;
      low_run_q   <= low_run_d;
    end
  end

  // result fields from the state after the step
  always_comb begin
    res_o.control_value     = ctrl_d;
    res_o.low_count         = low_d;
    res_o.high_count        = high_d;
    res_o.compare_low       = cmp_lo_d;
    res_o.compare_high      = cmp_hi_d;
    res_o.interrupt_request = irq;
    res_o.pulse_enable      = ctrl_d[CTL_LRUN] & pulse_routed_i;
    res_o.long_mode         = ctrl_d[CTL_LONG];
    res_o.half_cycle_clock  = ctrl_d[CTL_LONG] & ~ctrl_d[CTL_HRUN];
  end

  // register writes never move the counters
  a_write_holds_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en_i && item_i.op != OP_TICK) |=> ($stable(low_q) && $stable(high_q)))
    else $error("counter moved on a register write");

  // a stopped low half sits at its reload value
  a_stopped_low_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en_i && item_i.op == OP_TICK && !ctrl_q[CTL_LRUN])
      |=> (low_q == $past(reload_lo_q) && !low_run_q))
    else $error("stopped low half not at reload value");

  // no request, no state change
  a_idle_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_en_i |=> ($stable(ctrl_q) && $stable(cmp_lo_q) && $stable(cmp_hi_q)))
    else $error("state changed without a request");

endmodule

`default_nettype wire

>>> sv/drt_out_reg.sv
// result register towards the output channel
`timescale 1ns / 1ps
`default_nettype none

module drt_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  drt_pkg::result_t res_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output drt_pkg::result_t res_o
);
  import drt_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // room for a new result when empty or the current one is taken
  assign free_o = ~valid_q | out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

>>> sv/dual_reload_timer_with_cascade.sv
// Dual 8-bit reload timer with 16-bit cascade: top level.
// An accepted request is held in the input register; its step result is loaded into the
// result register once that register has room (it stalls while a result waits to be taken).
// Throughput: one tick or register write per cycle while the result channel is not stalled.
// Reset: all timer registers, counters and the pulse routing bit clear to zero,
// both pipeline stages empty; configuration writes are always accepted.
`timescale 1ns / 1ps
`default_nettype none

module dual_reload_timer_with_cascade (
  input  logic    clk_i,
  input  logic    rst_ni,
  drt_in_if.sink  in_i,
  drt_out_if.source out_o,
  drt_cfg_if.sink cfg_i
);
  import drt_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  logic    out_free;
  result_t step_res;
  result_t out_res;
  logic    pulse_routed_q;

  // pulse routing register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_routed_q <= 1'b0;
    end else if (cfg_i.valid) begin
      pulse_routed_q <= cfg_i.pulse_routed;
    end
  end

  // request stage
  assign in_item.op   = in_i.operation;
  assign in_item.data = in_i.write_data;

  drt_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_item_i    (in_item),
    .in_ready_o   (in_i.ready),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // step fires when a request is held and the result register has room
  assign advance = item_valid & out_free;

  drt_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_en_i      (advance),
    .item_i         (item),
    .pulse_routed_i (pulse_routed_q),
    .res_o          (step_res)
  );

  drt_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (step_res),
    .free_o      (out_free),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .res_o       (out_res)
  );

  // result channel payload
  assign out_o.control_value     = out_res.control_value;
  assign out_o.low_count         = out_res.low_count;
  assign out_o.high_count        = out_res.high_count;
  assign out_o.compare_low       = out_res.compare_low;
  assign out_o.compare_high      = out_res.compare_high;
  assign out_o.interrupt_request = out_res.interrupt_request;
  assign out_o.pulse_enable      = out_res.pulse_enable;
  assign out_o.long_mode         = out_res.long_mode;
  assign out_o.half_cycle_clock  = out_res.half_cycle_clock;

endmodule

`default_nettype wire
